// File: src/stq_pkg.sv
// shared types and constants for the sorted timer queue
package stq_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 31;
  localparam int ID_W            = 4;
  localparam int DELAY_W         = 31;
  localparam int OP_W            = 2;
  localparam int KIND_W          = 3;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_ARM    = 2'd1;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;

  localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ARMED     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_FIRE
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_REMOVE,
    CELL_INSERT,
    CELL_TICK,
    CELL_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t        op;
    logic [ID_W-1:0] id;
  } cell_cmd_t;

endpackage

// File: src/stq_cell.sv
// one list entry of the sorted timer chain
module stq_cell #(
  parameter int COUNT_BITS = stq_pkg::COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  stq_pkg::cell_cmd_t       cmd,
  input  logic [COUNT_BITS-1:0]    new_count,
  input  logic                     prev_match,
  input  logic                     prev_after,
  input  logic                     left_valid,
  input  logic [stq_pkg::ID_W-1:0] left_id,
  input  logic [COUNT_BITS-1:0]    left_count,
  input  logic                     right_valid,
  input  logic [stq_pkg::ID_W-1:0] right_id,
  input  logic [COUNT_BITS-1:0]    right_count,
  output logic                     valid,
  output logic [stq_pkg::ID_W-1:0] id,
  output logic [COUNT_BITS-1:0]    count,
  output logic                     match_any,
  output logic                     after
);

  logic                     valid_next;
  logic [stq_pkg::ID_W-1:0] id_next;
  logic [COUNT_BITS-1:0]    count_next;
  logic                     match_here;

  assign match_here = valid && (id == cmd.id);
  assign match_any  = prev_match || match_here;
  assign after      = !valid || (count > new_count);

  always_comb begin
    valid_next = valid;
    id_next    = id;
    count_next = count;
    unique case (cmd.op)
      stq_pkg::CELL_HOLD: begin
      end
      stq_pkg::CELL_REMOVE: begin
        if (match_any) begin
          valid_next = right_valid;
          id_next    = right_id;
          count_next = right_count;
        end
      end
      stq_pkg::CELL_INSERT: begin
        if (after) begin
          if (prev_after) begin
            valid_next = left_valid;
            id_next    = left_id;
            count_next = left_count;
          end else begin
            valid_next = 1'b1;
            id_next    = cmd.id;
            count_next = new_count;
          end
        end
      end
      stq_pkg::CELL_TICK: begin
        if (valid && (count != '0)) begin
          count_next = count - COUNT_BITS'(1);
        end
      end
      stq_pkg::CELL_POP: begin
        valid_next = right_valid;
        id_next    = right_id;
        count_next = right_count;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    id    <= id_next;
    count <= count_next;
  end

endmodule

// File: src/sorted_timer_queue_unit.sv
// top level of the sorted timer queue: control sequencer and chain of list cells
//
// Usage: drive op, timer_id and delay with start high; the item is taken at a
// rising edge where start is high and busy is low. busy stays high while the
// block works on an item.
// Results come out on kind, timer_id_res and last, valid for exactly one cycle
// while done is high; last marks the final result of an item. The receiver
// cannot hold results off, and the block never needs it to.
// The list lives in a row of TIMER_SLOTS cells kept sorted by remaining count;
// every step updates all cells at once; remove, insert and pop shift entries between neighbors.
// Sequence of each op, from the accepting edge:
//   cancel: result in the next cycle; the block stays idle and can take the next item at once.
//   arm: the accepting step removes an old entry and ST_INSERT inserts the new one;
//     the result is registered with the insert, and the next item is accepted then.
//   arm rejected when full: result in the next cycle.
//   tick: the accepting step decrements all cells, then ST_FIRE gives one fired result
//     per cycle, each popping the head cell; it returns to idle with no result when none is due.
// Op code 3 is dropped with no result.
// Reset (rst, synchronous) empties the list and clears done and busy.
module sorted_timer_queue_unit #(
  parameter int TIMER_SLOTS = stq_pkg::TIMER_SLOTS_DEF,
  parameter int COUNT_BITS  = stq_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [stq_pkg::OP_W-1:0]     op,
  input  logic [stq_pkg::ID_W-1:0]     timer_id,
  input  logic [stq_pkg::DELAY_W-1:0]  delay,
  output logic                         done,
  output logic [stq_pkg::KIND_W-1:0]   kind,
  output logic [stq_pkg::ID_W-1:0]     timer_id_res,
  output logic                         last
);

  stq_pkg::state_t state;
  stq_pkg::state_t state_next;
  stq_pkg::cell_cmd_t cmd;

  logic [stq_pkg::ID_W-1:0]   key_id;
  logic [COUNT_BITS-1:0]      key_count;
  logic [COUNT_BITS-1:0]      delay_sat;
  logic [COUNT_BITS-1:0]      delay_eff;

  logic                       done_next;
  logic [stq_pkg::KIND_W-1:0] kind_next;
  logic [stq_pkg::ID_W-1:0]   id_res_next;
  logic                       last_next;

  logic [TIMER_SLOTS-1:0]     cell_valid;
  logic [stq_pkg::ID_W-1:0]   cell_id    [TIMER_SLOTS];
  logic [COUNT_BITS-1:0]      cell_count [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0]     cell_match;
  logic [TIMER_SLOTS-1:0]     cell_after;

  logic accept;
  logic found;
  logic full;
  logic head_due;
  logic second_due;

  generate
    if (COUNT_BITS >= stq_pkg::DELAY_W) begin : g_wide
      assign delay_sat = COUNT_BITS'(delay);
    end else begin : g_narrow
      assign delay_sat = (|(delay >> COUNT_BITS)) ? '1 : delay[COUNT_BITS-1:0];
    end
  endgenerate

  assign delay_eff = (delay_sat == '0) ? COUNT_BITS'(1) : delay_sat;

  generate
    for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
      logic                     l_valid;
      logic [stq_pkg::ID_W-1:0] l_id;
      logic [COUNT_BITS-1:0]    l_count;
      logic                     l_match;
      logic                     l_after;
      logic                     r_valid;
      logic [stq_pkg::ID_W-1:0] r_id;
      logic [COUNT_BITS-1:0]    r_count;

      if (i == 0) begin : g_first
        assign l_valid = 1'b0;
        assign l_id    = '0;
        assign l_count = '0;
        assign l_match = 1'b0;
        assign l_after = 1'b0;
      end else begin : g_inner_l
        assign l_valid = cell_valid[i-1];
        assign l_id    = cell_id[i-1];
        assign l_count = cell_count[i-1];
        assign l_match = cell_match[i-1];
        assign l_after = cell_after[i-1];
      end

      if (i == TIMER_SLOTS - 1) begin : g_end
        assign r_valid = 1'b0;
        assign r_id    = '0;
        assign r_count = '0;
      end else begin : g_inner_r
        assign r_valid = cell_valid[i+1];
        assign r_id    = cell_id[i+1];
        assign r_count = cell_count[i+1];
      end

      stq_cell #(
        .COUNT_BITS(COUNT_BITS)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .cmd         (cmd),
        .new_count   (key_count),
        .prev_match  (l_match),
        .prev_after  (l_after),
        .left_valid  (l_valid),
        .left_id     (l_id),
        .left_count  (l_count),
        .right_valid (r_valid),
        .right_id    (r_id),
        .right_count (r_count),
        .valid       (cell_valid[i]),
        .id          (cell_id[i]),
        .count       (cell_count[i]),
        .match_any   (cell_match[i]),
        .after       (cell_after[i])
      );
    end
  endgenerate

  assign busy       = (state != stq_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign found      = cell_match[TIMER_SLOTS-1];
  assign full       = cell_valid[TIMER_SLOTS-1];
  assign head_due   = cell_valid[0] && (cell_count[0] == '0);
  assign second_due = cell_valid[1] && (cell_count[1] == '0);

  always_comb begin
    state_next  = state;
    cmd.op      = stq_pkg::CELL_HOLD;
    cmd.id      = (state == stq_pkg::ST_IDLE) ? timer_id : key_id;
    done_next   = 1'b0;
    kind_next   = stq_pkg::KIND_FIRED;
    id_res_next = timer_id;
    last_next   = 1'b1;
    unique case (state)
      stq_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op)
            stq_pkg::OP_TICK: begin
              cmd.op     = stq_pkg::CELL_TICK;
              state_next = stq_pkg::ST_FIRE;
            end
            stq_pkg::OP_ARM: begin
              if (found || !full) begin
                cmd.op     = stq_pkg::CELL_REMOVE;
                state_next = stq_pkg::ST_INSERT;
              end else begin
                done_next = 1'b1;
                kind_next = stq_pkg::KIND_FULL;
              end
            end
            stq_pkg::OP_CANCEL: begin
              cmd.op    = stq_pkg::CELL_REMOVE;
              done_next = 1'b1;
              kind_next = found ? stq_pkg::KIND_CANCELLED : stq_pkg::KIND_NOT_FOUND;
            end
            default: begin
            end
          endcase
        end
      end
      stq_pkg::ST_INSERT: begin
        cmd.op      = stq_pkg::CELL_INSERT;
        done_next   = 1'b1;
        kind_next   = stq_pkg::KIND_ARMED;
        id_res_next = key_id;
        state_next  = stq_pkg::ST_IDLE;
      end
      stq_pkg::ST_FIRE: begin
        id_res_next = cell_id[0];
        last_next   = !second_due;
        if (head_due) begin
          cmd.op    = stq_pkg::CELL_POP;
          done_next = 1'b1;
          if (!second_due) begin
            state_next = stq_pkg::ST_IDLE;
          end
        end else begin
          state_next = stq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stq_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    kind         <= kind_next;
    timer_id_res <= id_res_next;
    last         <= last_next;
    if (accept) begin
      key_id    <= timer_id;
      key_count <= delay_eff;
    end
  end

  // armed entries always fill the chain from the head
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("valid cells do not form a prefix");

  // busy drops exactly with the final result of an item
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (last == !busy))
    else $error("last flag and busy disagree");

  // an insert step always has a free cell at the tail
  a_room: assert property (@(posedge clk) disable iff (rst)
    (state == stq_pkg::ST_INSERT) |-> !cell_valid[TIMER_SLOTS-1])
    else $error("insert with full chain");

  // a due head cell in the fire state is always reported as a fired result
  a_fire_pop: assert property (@(posedge clk) disable iff (rst)
    (state == stq_pkg::ST_FIRE && head_due) |=> (done && kind == stq_pkg::KIND_FIRED))
    else $error("due head not reported");

endmodule

// File: sim/tb.sv
// self-checking testbench for the sorted timer queue unit
`timescale 1ns / 1ps

module tb;

  localparam int SLOTS = stq_pkg::TIMER_SLOTS_DEF;
  localparam int CNT_W = stq_pkg::COUNT_BITS_DEF;
  localparam logic [stq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 24;

  typedef struct {
    logic [stq_pkg::OP_W-1:0]    op;
    logic [stq_pkg::ID_W-1:0]    id;
    logic [stq_pkg::DELAY_W-1:0] dly;
    int                          idle_pct;
  } timer_cmd_t;

  typedef struct {
    logic [stq_pkg::KIND_W-1:0] kind;
    logic [stq_pkg::ID_W-1:0]   id;
    logic                       last;
  } timer_event_t;

  typedef struct {
    logic [stq_pkg::ID_W-1:0] id;
    logic [CNT_W-1:0]         cnt;
  } armed_timer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [stq_pkg::OP_W-1:0] op = stq_pkg::OP_TICK;
  logic [stq_pkg::ID_W-1:0] timer_id = '0;
  logic [stq_pkg::DELAY_W-1:0] delay = '0;
  logic busy, done, last;
  logic [stq_pkg::KIND_W-1:0] kind;
  logic [stq_pkg::ID_W-1:0] timer_id_res;

  timer_cmd_t   pending_cmds[$];
  timer_event_t expected_events[$];
  armed_timer_t timer_list[$];
  bit item_taken = 0;
  bit presenting = 0;
  int mismatches = 0;

  sorted_timer_queue_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .timer_id(timer_id), .delay(delay),
    .done(done), .kind(kind), .timer_id_res(timer_id_res), .last(last)
  );

  always #1 clk = ~clk;

  function automatic int find_timer(logic [stq_pkg::ID_W-1:0] id);
    foreach (timer_list[i])
      if (timer_list[i].id == id) return i;
    return -1;
  endfunction

  function automatic void push_event(logic [stq_pkg::KIND_W-1:0] k,
                                     logic [stq_pkg::ID_W-1:0] id, logic l);
    timer_event_t e;
    e.kind = k;
    e.id = id;
    e.last = l;
    expected_events.push_back(e);
  endfunction

  function automatic void predict_timer_events(logic [stq_pkg::OP_W-1:0] c_op,
                                               logic [stq_pkg::ID_W-1:0] c_id,
                                               logic [stq_pkg::DELAY_W-1:0] c_dly);
    int pos;
    int p;
    logic [CNT_W-1:0] d;
    armed_timer_t t;
    case (c_op)
      stq_pkg::OP_TICK: begin
        foreach (timer_list[i])
          if (timer_list[i].cnt != 0) timer_list[i].cnt--;
        while (timer_list.size() > 0 && timer_list[0].cnt == 0) begin
          push_event(stq_pkg::KIND_FIRED, timer_list[0].id,
                     timer_list.size() == 1 || timer_list[1].cnt != 0);
          void'(timer_list.pop_front());
        end
      end
      stq_pkg::OP_ARM: begin
        d = (c_dly == '0) ? CNT_W'(1) : CNT_W'(c_dly);
        pos = find_timer(c_id);
        if (pos >= 0) begin
          timer_list.delete(pos);
        end else if (timer_list.size() >= SLOTS) begin
          push_event(stq_pkg::KIND_FULL, c_id, 1'b1);
          return;
        end
        p = 0;
        while (p < timer_list.size() && timer_list[p].cnt <= d) p++;
        t.id = c_id;
        t.cnt = d;
        timer_list.insert(p, t);
        push_event(stq_pkg::KIND_ARMED, c_id, 1'b1);
      end
      stq_pkg::OP_CANCEL: begin
        pos = find_timer(c_id);
        if (pos >= 0) begin
          timer_list.delete(pos);
          push_event(stq_pkg::KIND_CANCELLED, c_id, 1'b1);
        end else begin
          push_event(stq_pkg::KIND_NOT_FOUND, c_id, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void push_cmd(logic [stq_pkg::OP_W-1:0] c_op,
                                   logic [stq_pkg::ID_W-1:0] c_id,
                                   logic [stq_pkg::DELAY_W-1:0] c_dly, int idle);
    timer_cmd_t c;
    c.op = c_op;
    c.id = c_id;
    c.dly = c_dly;
    c.idle_pct = idle;
    pending_cmds.push_back(c);
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (item_taken) begin
        void'(pending_cmds.pop_front());
        item_taken = 0;
        presenting = 0;
      end
      if (!presenting) begin
        if (pending_cmds.size() > 0 &&
            $urandom_range(99) >= pending_cmds[0].idle_pct) begin
          op <= pending_cmds[0].op;
          timer_id <= pending_cmds[0].id;
          delay <= pending_cmds[0].dly;
          start <= 1'b1;
          presenting = 1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    timer_event_t e;
    if (!rst) begin
      if (done) begin
        if (expected_events.size() == 0) begin
          $error("result with nothing expected: kind %0d id %0d last %0d",
                 kind, timer_id_res, last);
          mismatches++;
        end else begin
          e = expected_events.pop_front();
          if (kind !== e.kind) begin
            $error("kind: expected %0d, actual %0d", e.kind, kind);
            mismatches++;
          end
          if (timer_id_res !== e.id) begin
            $error("timer_id_res: expected %0d, actual %0d", e.id, timer_id_res);
            mismatches++;
          end
          if (last !== e.last) begin
            $error("last: expected %0d, actual %0d", e.last, last);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        predict_timer_events(op, timer_id, delay);
        item_taken = 1;
      end
    end
  end

  initial begin
    int idle_pcts[3];
    logic [stq_pkg::OP_W-1:0] r_op;
    logic [stq_pkg::DELAY_W-1:0] r_dly;
    int r;
    idle_pcts = '{34, 83, 0};

    // directed items
    push_cmd(stq_pkg::OP_TICK, 4'd0, '0, 0);
    push_cmd(OP_UNUSED, 4'd9, '1, 0);
    push_cmd(stq_pkg::OP_CANCEL, 4'd5, '0, 0);
    push_cmd(stq_pkg::OP_ARM, 4'd0, '0, 0);
    push_cmd(stq_pkg::OP_ARM, 4'd15, '1, 0);
    push_cmd(stq_pkg::OP_CANCEL, 4'd15, '0, 0);
    push_cmd(stq_pkg::OP_TICK, 4'd15, '1, 0);
    for (int i = 0; i < SLOTS; i++)
      push_cmd(stq_pkg::OP_ARM, i[stq_pkg::ID_W-1:0], 31'd1, 0);
    push_cmd(stq_pkg::OP_ARM, 4'd7, '0, 0);
    push_cmd(stq_pkg::OP_TICK, 4'd0, '0, 0);

    // random items, one block per idle setting
    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < 95; n++) begin
        r = $urandom_range(99);
        r_op = (r < 40) ? stq_pkg::OP_TICK : (r < 78) ? stq_pkg::OP_ARM :
               (r < 97) ? stq_pkg::OP_CANCEL : OP_UNUSED;
        case ($urandom_range(19))
          0: r_dly = '0;
          1, 2: r_dly = stq_pkg::DELAY_W'($urandom);
          3: r_dly = '1;
          4, 5, 6, 7: r_dly = stq_pkg::DELAY_W'($urandom_range(40, 1));
          default: r_dly = stq_pkg::DELAY_W'($urandom_range(6, 1));
        endcase
        push_cmd(r_op, stq_pkg::ID_W'($urandom_range(15)), r_dly, idle_pcts[ph]);
      end
    end

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0) @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_events.size() != 0) begin
      $error("%0d expected results never arrived", expected_events.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
